// File: sv/lsre_pkg.sv
// Package: opcodes, function codes and result types for the execute step core.
`timescale 1ns / 1ps
package lsre_pkg;

   typedef logic [5:0] opcode_type;

   localparam opcode_type OP_SPECIAL  = 6'h00;
   localparam opcode_type OP_REGIMM   = 6'h01;
   localparam opcode_type OP_J        = 6'h02;
   localparam opcode_type OP_JAL      = 6'h03;
   localparam opcode_type OP_BEQ      = 6'h04;
   localparam opcode_type OP_BNE      = 6'h05;
   localparam opcode_type OP_BLEZ     = 6'h06;
   localparam opcode_type OP_BGTZ     = 6'h07;
   localparam opcode_type OP_ADDI     = 6'h08;
   localparam opcode_type OP_SLTI     = 6'h0a;
   localparam opcode_type OP_ANDI     = 6'h0c;
   localparam opcode_type OP_ORI      = 6'h0d;
   localparam opcode_type OP_XORI     = 6'h0e;
   localparam opcode_type OP_LUI      = 6'h0f;
   localparam opcode_type OP_SPECIAL2 = 6'h1c;
   localparam opcode_type OP_LB       = 6'h20;
   localparam opcode_type OP_LH       = 6'h21;
   localparam opcode_type OP_LW       = 6'h23;
   localparam opcode_type OP_SB       = 6'h28;
   localparam opcode_type OP_SH       = 6'h29;
   localparam opcode_type OP_SW       = 6'h2b;

   localparam opcode_type FN_SLL  = 6'h00;
   localparam opcode_type FN_SRL  = 6'h02;
   localparam opcode_type FN_SLLV = 6'h04;
   localparam opcode_type FN_SRLV = 6'h06;
   localparam opcode_type FN_JR   = 6'h08;
   localparam opcode_type FN_ADD  = 6'h20;
   localparam opcode_type FN_SUB  = 6'h22;
   localparam opcode_type FN_AND  = 6'h24;
   localparam opcode_type FN_OR   = 6'h25;
   localparam opcode_type FN_XOR  = 6'h26;
   localparam opcode_type FN_SLT  = 6'h2a;
   localparam opcode_type FN_MUL  = 6'h02;

   localparam logic [31:0] SYSCALL_WORD = 32'h0000000c;
   localparam logic [20:0] JR_LOW_BITS  = 21'h000008;
   localparam logic [31:0] EXIT_SERVICE = 32'd10;
   localparam logic [31:0] PC_REGION    = 32'hF0000000;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        is_syscall;
      logic [31:0] service_code;
      logic [31:0] service_argument;
      logic        exit_request;
   } rsp_type;

endpackage

// File: sv/lsre_stream_if.sv
// Valid/ready stream interface carrying one item of a given width.
`timescale 1ns / 1ps
interface lsre_stream_if #(parameter int WIDTH = 32);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/load_store_risc_execute_step_core.sv
// Top level: single-pass execute step of a small load/store RISC core.
`timescale 1ns / 1ps
// Channel   Dir  Payload                          Handshake
// req       in   instruction[31:0]                req.valid / req.ready
// rsp       out  lsre_pkg::rsp_type (next_pc ...) rsp.valid / rsp.ready
//
// An instruction is decoded and executed in the execute stage after it is taken from req;
// its item lands in a one-deep result register, so one instruction per clock while rsp is not stalled.
// Data memory is four byte-lane RAMs read in the accept cycle (registered read);
// loads/stores resolve in the execute stage, and a following item's load sees the
// bytes of the store in flight through a forward compare per lane.
// Reset clears registers, pc and the memory; the clearing pass writes all
// DATA_BYTES/4 words, during which req.ready stays low.
// req.ready drops only when the result register is full and rsp is stalled, or while the clearing pass runs.
module load_store_risc_execute_step_core #(
   parameter int DATA_BYTES = 4096
) (
   input  logic clock,
   input  logic reset,
   lsre_stream_if.sink   req,
   lsre_stream_if.source rsp
);
   localparam int WORDS = DATA_BYTES / 4;
   localparam int WAW   = $clog2(WORDS);
   localparam int BAW   = WAW + 2;

   // ---- clearing pass ----
   logic           clr_busy_ff, clr_busy_in;
   logic [WAW-1:0] clr_addr_ff, clr_addr_in;

   // ---- execute stage ----
   logic        ex_valid_ff, ex_valid_in;
   logic [31:0] ex_instr_ff;
   logic [31:0] rf_ff [32];
   logic [31:0] pc_ff;

   logic        out_valid_ff;
   lsre_pkg::rsp_type out_ff;

   logic advance;
   assign advance = !out_valid_ff || rsp.ready;
   assign req.ready = advance && !clr_busy_ff;
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;

   // decode of the item in execute
   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sh;
   logic [31:0] a, b, imm, simm, addr, br_target;
   assign op = ex_instr_ff[31:26];
   assign rs = ex_instr_ff[25:21];
   assign rt = ex_instr_ff[20:16];
   assign rd = ex_instr_ff[15:11];
   assign sh = ex_instr_ff[10:6];
   assign fn = ex_instr_ff[5:0];
   assign imm  = {16'h0, ex_instr_ff[15:0]};
   assign simm = {{16{ex_instr_ff[15]}}, ex_instr_ff[15:0]};
   assign a = rf_ff[rs];
   assign b = rf_ff[rt];
   assign addr = a + simm;
   assign br_target = pc_ff + {simm[29:0], 2'b00};

   // memory address of the request being accepted: needs the register file
   // as it will be after the item in execute, so a forward of its write.
   logic [31:0] rq_w;
   logic [4:0]  rq_rs;
   logic [31:0] rq_a, rq_addr;
   logic        wb_en;
   logic [4:0]  wb_reg;
   logic [31:0] wb_val;
   assign rq_w  = req.data;
   assign rq_rs = rq_w[25:21];
   assign rq_a  = (wb_en && wb_reg == rq_rs && rq_rs != 5'd0) ? wb_val : rf_ff[rq_rs];
   assign rq_addr = rq_a + {{16{rq_w[15]}}, rq_w[15:0]};

   // byte lane addressing: lane k holds bytes with addr[1:0]==k
   logic [BAW-1:0] rq_ba;
   assign rq_ba = rq_addr[BAW-1:0];

   logic [WAW-1:0] rd_word [4];
   logic [7:0]     rd_byte [4];
   logic           mem_we  [4];
   logic [WAW-1:0] mem_wa  [4];
   logic [7:0]     mem_wd  [4];

   logic [BAW-1:0] ex_ba;
   assign ex_ba = addr[BAW-1:0];

   // store of the item in execute: byte j goes to byte address ex_ba+j
   logic [2:0] st_len;
   always_comb begin
      case (op)
         lsre_pkg::OP_SB: st_len = 3'd1;
         lsre_pkg::OP_SH: st_len = 3'd2;
         lsre_pkg::OP_SW: st_len = 3'd4;
         default:         st_len = 3'd0;
      endcase
   end

   // forwarding record: lane write made on the last advance vs. the registered read
   logic           fw_hit_ff [4];
   logic [7:0]     fw_data_ff [4];

   // read address held while stalled so the registered read stays good;
   // a stalled item sees no store (only the executing item stores on advance)
   logic [WAW-1:0] rd_hold_ff [4];

   genvar k;
   generate
      for (k = 0; k < 4; k++) begin : g_lane
         logic [BAW-1:0] rb, sb;
         logic [1:0]     rj, sj;
         logic [7:0]     sd;
         logic           sv;
         logic [7:0]     ram_q;
         // read: the byte of the request that falls in lane k
         assign rj = 2'(k) - rq_ba[1:0];
         assign rb = rq_ba + BAW'(rj);
         assign rd_word[k] = rb[BAW-1:2];
         // write: store byte that falls in lane k
         assign sj = 2'(k) - ex_ba[1:0];
         assign sb = ex_ba + BAW'(sj);
         assign sd = b[8*sj +: 8];
         assign sv = ex_valid_ff && advance && ({1'b0, sj} < st_len);
         always_comb begin
            if (clr_busy_ff) begin
               mem_we[k] = 1'b1;
               mem_wa[k] = clr_addr_ff;
               mem_wd[k] = 8'h00;
            end else begin
               mem_we[k] = sv;
               mem_wa[k] = sb[BAW-1:2];
               mem_wd[k] = sd;
            end
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               fw_hit_ff[k]  <= sv && (sb[BAW-1:2] == rb[BAW-1:2]);
               fw_data_ff[k] <= sd;
            end
         end
         lsre_ram #(.WIDTH(8), .DEPTH(WORDS)) u_ram (
            .clock  (clock),
            .wr_en  (mem_we[k]),
            .wr_addr(mem_wa[k]),
            .wr_data(mem_wd[k]),
            .rd_addr(advance ? rd_word[k] : rd_hold_ff[k]),
            .rd_data(ram_q)
         );
         assign rd_byte[k] = fw_hit_ff[k] ? fw_data_ff[k] : ram_q;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 4; i++) rd_hold_ff[i] <= rd_word[i];
      end
   end

   // load data, byte j from lane (ex_ba+j)
   logic [31:0] ld_word;
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         ld_word[8*j +: 8] = rd_byte[2'(ex_ba[1:0] + 2'(j))];
      end
   end

   logic [31:0] next_pc, mul_res;
   logic        sys;
   assign mul_res = a * b;
   assign sys = (ex_instr_ff == lsre_pkg::SYSCALL_WORD);

   always_comb begin
      wb_en   = 1'b0;
      wb_reg  = rd;
      wb_val  = 32'h0;
      next_pc = pc_ff + 32'd4;
      if (op == lsre_pkg::OP_SPECIAL) begin
         if (sys) begin
            wb_en = 1'b0;
         end else if (ex_instr_ff[20:0] == lsre_pkg::JR_LOW_BITS) begin
            next_pc = a;
         end else begin
            wb_en = 1'b1;
            case (fn)
               lsre_pkg::FN_ADD:  wb_val = a + b;
               lsre_pkg::FN_SUB:  wb_val = a - b;
               lsre_pkg::FN_AND:  wb_val = a & b;
               lsre_pkg::FN_OR:   wb_val = a | b;
               lsre_pkg::FN_XOR:  wb_val = a ^ b;
               lsre_pkg::FN_SLLV: wb_val = b << a[4:0];
               lsre_pkg::FN_SRLV: wb_val = b >> a[4:0];
               lsre_pkg::FN_SLT:  wb_val = {31'h0, $signed(a) < $signed(b)};
               lsre_pkg::FN_SLL: begin
                  wb_en = (rs == 5'd0);
                  wb_val = b << sh;
               end
               lsre_pkg::FN_SRL: begin
                  wb_en = (rs == 5'd0);
                  wb_val = b >> sh;
               end
               default: wb_en = 1'b0;
            endcase
         end
      end else begin
         wb_reg = rt;
         case (op)
            lsre_pkg::OP_SPECIAL2: begin
               wb_reg = rd;
               wb_en = (fn == lsre_pkg::FN_MUL);
               wb_val = mul_res;
            end
            lsre_pkg::OP_ADDI: begin wb_en = 1'b1; wb_val = a + simm; end
            lsre_pkg::OP_ANDI: begin wb_en = 1'b1; wb_val = a & imm; end
            lsre_pkg::OP_ORI:  begin wb_en = 1'b1; wb_val = a | imm; end
            lsre_pkg::OP_XORI: begin wb_en = 1'b1; wb_val = a ^ imm; end
            lsre_pkg::OP_SLTI: begin
               wb_en = 1'b1;
               wb_val = {31'h0, $signed(a) < $signed(simm)};
            end
            lsre_pkg::OP_LUI: begin wb_en = 1'b1; wb_val = {imm[15:0], 16'h0}; end
            lsre_pkg::OP_LB: begin
               wb_en = 1'b1;
               wb_val = {{24{ld_word[7]}}, ld_word[7:0]};
            end
            lsre_pkg::OP_LH: begin
               wb_en = 1'b1;
               wb_val = {{16{ld_word[15]}}, ld_word[15:0]};
            end
            lsre_pkg::OP_LW: begin wb_en = 1'b1; wb_val = ld_word; end
            lsre_pkg::OP_BEQ:  if (a == b) next_pc = br_target;
            lsre_pkg::OP_BNE:  if (a != b) next_pc = br_target;
            lsre_pkg::OP_BLEZ: if (a == 32'h0 || a[31]) next_pc = br_target;
            lsre_pkg::OP_BGTZ: if (a != 32'h0 && !a[31]) next_pc = br_target;
            lsre_pkg::OP_REGIMM: begin
               if ((rt == 5'd0 && a[31]) || (rt == 5'd1 && !a[31])) next_pc = br_target;
            end
            lsre_pkg::OP_J: begin
               next_pc = (pc_ff & lsre_pkg::PC_REGION) | {4'h0, ex_instr_ff[25:0], 2'b00};
            end
            lsre_pkg::OP_JAL: begin
               wb_en = 1'b1;
               wb_reg = 5'd31;
               wb_val = pc_ff + 32'd4;
               next_pc = (pc_ff & lsre_pkg::PC_REGION) | {4'h0, ex_instr_ff[25:0], 2'b00};
            end
            default: wb_en = 1'b0;
         endcase
      end
      wb_en = wb_en && ex_valid_ff && (wb_reg != 5'd0);
   end

   assign ex_valid_in = req.valid && req.ready;
   assign clr_busy_in = clr_busy_ff && (clr_addr_ff != WAW'(WORDS - 1));
   assign clr_addr_in = clr_addr_ff + WAW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         ex_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff        <= 32'h0;
         for (int i = 0; i < 32; i++) rf_ff[i] <= 32'h0;
      end else begin
         if (clr_busy_ff) begin
            clr_busy_ff <= clr_busy_in;
            clr_addr_ff <= clr_addr_in;
         end
         if (advance) begin
            ex_valid_ff  <= ex_valid_in;
            out_valid_ff <= ex_valid_ff;
            if (ex_valid_in) ex_instr_ff <= req.data;
            if (ex_valid_ff) begin
               pc_ff <= next_pc;
               if (wb_en) rf_ff[wb_reg] <= wb_val;
               out_ff.next_pc          <= next_pc;
               out_ff.is_syscall       <= sys;
               out_ff.service_code     <= sys ? rf_ff[2] : 32'h0;
               out_ff.service_argument <= sys ? rf_ff[4] : 32'h0;
               out_ff.exit_request     <= sys && (rf_ff[2] == lsre_pkg::EXIT_SERVICE);
            end
         end
      end
   end
endmodule

// File: sv/lsre_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module lsre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
